>>> rtl/proximity_weighted_wheel_speed_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for proximity_weighted_wheel_speed
// Short forms for clocked assertions with the block's clock and reset.
// ----------------------------------------------------------------------------
`ifndef PROXIMITY_WEIGHTED_WHEEL_SPEED_MACROS_SVH
`define PROXIMITY_WEIGHTED_WHEEL_SPEED_MACROS_SVH

// same-cycle implication
`define PWWS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// implication after a fixed number of cycles
`define PWWS_ASSERT_DLY(label, ante, n, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> ##n (cons)) else $error(msg);

`endif

>>> rtl/pwws_pkg.sv
// ----------------------------------------------------------------------------
// pwws_pkg
// Types, register codes and weight table of the wheel speed pipeline.
// ----------------------------------------------------------------------------
package pwws_pkg;

  localparam int NUM_SENSORS = 9;
  localparam int PROX_W      = 12;
  localparam int CMD_W       = 8;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CRUISE_SPEED    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_BAND       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HALVE_THRESHOLD = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR_ZERO_BAND  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INVERSE_SCALE   = 3'd5;

  // register reset values
  localparam logic [15:0] CRUISE_SPEED_RST    = 16'd30000;
  localparam logic [15:0] DEAD_BAND_RST       = 16'd1000;
  localparam logic [17:0] HALVE_THRESHOLD_RST = 18'd2500;
  localparam logic [15:0] SPEED_LIMIT_RST     = 16'd24000;
  localparam logic [9:0]  NEAR_ZERO_BAND_RST  = 10'd50;
  localparam logic [23:0] INVERSE_SCALE_RST   = 24'd11639;

  typedef logic signed [4:0] weight_t;

  localparam weight_t WEIGHT_ROWS [2][NUM_SENSORS] = '{
    '{5'sd2, -5'sd2, -5'sd4, -5'sd12, 5'sd5, 5'sd2, 5'sd2, 5'sd2, 5'sd4},
    '{5'sd2, 5'sd2, 5'sd2, 5'sd5, -5'sd12, -5'sd4, -5'sd2, 5'sd2, 5'sd4}
  };

  typedef struct packed {
    logic [PROX_W-1:0] prox_0;
    logic [PROX_W-1:0] prox_1;
    logic [PROX_W-1:0] prox_2;
    logic [PROX_W-1:0] prox_3;
    logic [PROX_W-1:0] prox_4;
    logic [PROX_W-1:0] prox_5;
    logic [PROX_W-1:0] prox_6;
    logic [PROX_W-1:0] prox_7;
    logic [PROX_W-1:0] prox_8;
  } frame_t;

  typedef struct packed {
    logic signed [CMD_W-1:0] left_speed;
    logic signed [CMD_W-1:0] right_speed;
  } result_t;

endpackage

>>> rtl/proximity_weighted_wheel_speed.sv
// ----------------------------------------------------------------------------
// proximity_weighted_wheel_speed
// Obstacle avoidance: nine proximity readings to two wheel speed commands.
// ----------------------------------------------------------------------------
//  channel | handshake                     | payload
//  --------+-------------------------------+-----------------------------
//  frame   | start / busy                  | frame_i   (pwws_pkg::frame_t)
//  result  | result_valid_o (no backpress) | result_o  (pwws_pkg::result_t)
//  config  | cfg_valid_i / cfg_ready_o     | cfg_index_i, cfg_data_i
//
//  One frame per cycle; each result comes out of the register stages below.
//  There are six register stages: potentials, speed select/halve,
//  boost/clamp, balance/magnitude, scale multiply, saturate.
//  Reset loads the register defaults and empties the pipeline.
//  busy stays low and nothing stalls, since the receiver cannot hold off.
// ----------------------------------------------------------------------------
`include "proximity_weighted_wheel_speed_macros.svh"

module proximity_weighted_wheel_speed (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  pwws_pkg::frame_t                   frame_i,
  output logic                               result_valid_o,
  output pwws_pkg::result_t                  result_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [pwws_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [pwws_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int POT_W  = 18;  // |potential| <= 73710
  localparam int SPD_W  = 22;  // speeds before clamp, Q2
  localparam int CLP_W  = 19;  // clamped speeds, |s| <= 4*65535
  localparam int CMP_W  = 21;  // 3x clamped speed
  localparam int MAG_W  = 18;
  localparam int PROD_W = 42;
  localparam int Q_W    = PROD_W - 26;

  typedef logic signed [POT_W-1:0] pot_t;
  typedef logic signed [SPD_W-1:0] spd_t;
  typedef logic signed [CLP_W-1:0] clp_t;
  typedef logic signed [CMP_W-1:0] cmp_t;

  // ---------------------------------------------------------------- config
  logic [15:0] cruise_q, dead_band_q, limit_q;
  logic [17:0] halve_thr_q;
  logic [9:0]  nzb_q;
  logic [23:0] scale_q;

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cruise_q    <= pwws_pkg::CRUISE_SPEED_RST;
      dead_band_q <= pwws_pkg::DEAD_BAND_RST;
      halve_thr_q <= pwws_pkg::HALVE_THRESHOLD_RST;
      limit_q     <= pwws_pkg::SPEED_LIMIT_RST;
      nzb_q       <= pwws_pkg::NEAR_ZERO_BAND_RST;
      scale_q     <= pwws_pkg::INVERSE_SCALE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        pwws_pkg::REG_CRUISE_SPEED:    cruise_q    <= cfg_data_i[15:0];
        pwws_pkg::REG_DEAD_BAND:       dead_band_q <= cfg_data_i[15:0];
        pwws_pkg::REG_HALVE_THRESHOLD: halve_thr_q <= cfg_data_i[17:0];
        pwws_pkg::REG_SPEED_LIMIT:     limit_q     <= cfg_data_i[15:0];
        pwws_pkg::REG_NEAR_ZERO_BAND:  nzb_q       <= cfg_data_i[9:0];
        pwws_pkg::REG_INVERSE_SCALE:   scale_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- valids
  logic v1_q, v2_q, v3_q, v4_q, v5_q, vout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      v5_q   <= 1'b0;
      vout_q <= 1'b0;
    end else begin
      v1_q   <= start && !busy;
      v2_q   <= v1_q;
      v3_q   <= v2_q;
      v4_q   <= v3_q;
      v5_q   <= v4_q;
      vout_q <= v5_q;
    end
  end

  // ---------------------------------------------------- stage 1: potentials
  logic [pwws_pkg::PROX_W-1:0] prox [pwws_pkg::NUM_SENSORS];
  pot_t pot0_d, pot1_d, pot0_q, pot1_q;

  assign prox[0] = frame_i.prox_0;
  assign prox[1] = frame_i.prox_1;
  assign prox[2] = frame_i.prox_2;
  assign prox[3] = frame_i.prox_3;
  assign prox[4] = frame_i.prox_4;
  assign prox[5] = frame_i.prox_5;
  assign prox[6] = frame_i.prox_6;
  assign prox[7] = frame_i.prox_7;
  assign prox[8] = frame_i.prox_8;

  always_comb begin
    pot0_d = '0;
    pot1_d = '0;
    for (int s = 0; s < pwws_pkg::NUM_SENSORS; s++) begin
      pot0_d = pot0_d + POT_W'(pwws_pkg::WEIGHT_ROWS[0][s]) * POT_W'($signed({1'b0, prox[s]}));
      pot1_d = pot1_d + POT_W'(pwws_pkg::WEIGHT_ROWS[1][s]) * POT_W'($signed({1'b0, prox[s]}));
    end
  end

  always_ff @(posedge clk_i) begin
    pot0_q <= pot0_d;
    pot1_q <= pot1_d;
  end

  // ------------------------------------------- stage 2: speed select, halve
  logic [POT_W-1:0] mag0_p, mag1_p;
  logic             dead, halve0, halve1;
  spd_t             cruise4, raw0, raw1, sel0, sel1, spd0_d, spd1_d, spd0_q, spd1_q;

  function automatic spd_t half_spd(spd_t v);
    // C-style divide by two, rounds toward zero
    half_spd = $signed(v + {{(SPD_W-1){1'b0}}, v[SPD_W-1]}) >>> 1;
  endfunction

  function automatic clp_t half_clp(clp_t v);
    half_clp = $signed(v + {{(CLP_W-1){1'b0}}, v[CLP_W-1]}) >>> 1;
  endfunction

  always_comb begin
    mag0_p  = pot0_q[POT_W-1] ? POT_W'(-pot0_q) : POT_W'(pot0_q);
    mag1_p  = pot1_q[POT_W-1] ? POT_W'(-pot1_q) : POT_W'(pot1_q);
    dead    = (mag0_p < {2'b00, dead_band_q}) && (mag1_p < {2'b00, dead_band_q});
    halve0  = mag0_p > halve_thr_q;
    halve1  = !halve0 && (mag1_p > halve_thr_q);
    cruise4 = $signed({4'b0000, cruise_q, 2'b00});
    raw0    = ((SPD_W'(pot0_q) <<< 1) + SPD_W'(pot0_q) + $signed({6'b0, cruise_q})) <<< 2;
    raw1    = ((SPD_W'(pot1_q) <<< 1) + SPD_W'(pot1_q) + $signed({6'b0, cruise_q})) <<< 2;
    sel0    = dead ? cruise4 : raw0;
    sel1    = dead ? cruise4 : raw1;
    spd0_d  = halve0 ? half_spd(sel0) : sel0;
    spd1_d  = halve1 ? half_spd(sel1) : sel1;
  end

  always_ff @(posedge clk_i) begin
    spd0_q <= spd0_d;
    spd1_q <= spd1_d;
  end

  // ---------------------------------------------- stage 3: boost and clamp
  spd_t band_s, lim_s, bst0, bst1, pre0, pre1;
  logic near;
  clp_t clp0_d, clp1_d, clp0_q, clp1_q;

  always_comb begin
    band_s = $signed({10'b0, nzb_q, 2'b00});
    lim_s  = $signed({4'b0000, limit_q, 2'b00});
    near   = (spd0_q < band_s) && (spd0_q > -band_s) &&
             (spd1_q < band_s) && (spd1_q > -band_s);
    bst0   = (spd0_q <<< 4) + (spd0_q <<< 2);
    bst1   = (spd1_q <<< 4) + (spd1_q <<< 2);
    pre0   = near ? bst0 : spd0_q;
    pre1   = near ? bst1 : spd1_q;
    if (pre0 > lim_s) begin
      clp0_d = CLP_W'(lim_s);
    end else if (pre0 < -lim_s) begin
      clp0_d = CLP_W'(-lim_s);
    end else begin
      clp0_d = CLP_W'(pre0);
    end
    if (pre1 > lim_s) begin
      clp1_d = CLP_W'(lim_s);
    end else if (pre1 < -lim_s) begin
      clp1_d = CLP_W'(-lim_s);
    end else begin
      clp1_d = CLP_W'(pre1);
    end
  end

  always_ff @(posedge clk_i) begin
    clp0_q <= clp0_d;
    clp1_q <= clp1_d;
  end

  // ----------------------------------------- stage 4: balance, magnitude
  cmp_t two0, two1, three0, three1;
  logic imbalance;
  clp_t bal0, bal1, abs0, abs1;
  logic [MAG_W-1:0] mag0_d, mag1_d, mag0_q, mag1_q;
  logic neg0_q4, neg1_q4;

  always_comb begin
    two0      = CMP_W'(clp0_q) <<< 1;
    two1      = CMP_W'(clp1_q) <<< 1;
    three0    = two0 + CMP_W'(clp0_q);
    three1    = two1 + CMP_W'(clp1_q);
    imbalance = (two1 > three0) || (three1 < two0);
    bal0      = imbalance ? half_clp(clp0_q) : clp0_q;
    bal1      = imbalance ? half_clp(clp1_q) : clp1_q;
    abs0      = bal0[CLP_W-1] ? -bal0 : bal0;
    abs1      = bal1[CLP_W-1] ? -bal1 : bal1;
    mag0_d    = abs0[MAG_W-1:0];
    mag1_d    = abs1[MAG_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    mag0_q  <= mag0_d;
    mag1_q  <= mag1_d;
    neg0_q4 <= bal0[CLP_W-1];
    neg1_q4 <= bal1[CLP_W-1];
  end

  // ---------------------------------------------------- stage 5: scaling
  logic [PROD_W-1:0] prod0, prod1;
  logic [Q_W-1:0]    q0_q, q1_q;
  logic              neg0_q5, neg1_q5;

  assign prod0 = PROD_W'(mag0_q) * PROD_W'(scale_q);
  assign prod1 = PROD_W'(mag1_q) * PROD_W'(scale_q);

  always_ff @(posedge clk_i) begin
    q0_q    <= prod0[PROD_W-1:26];
    q1_q    <= prod1[PROD_W-1:26];
    neg0_q5 <= neg0_q4;
    neg1_q5 <= neg1_q4;
  end

  // -------------------------------------------------- stage 6: saturation
  logic [pwws_pkg::CMD_W-1:0] cmd0, cmd1;
  pwws_pkg::result_t res_d, res_q;

  always_comb begin
    cmd0 = (q0_q > Q_W'(127)) ? 8'd127 : {1'b0, q0_q[6:0]};
    cmd1 = (q1_q > Q_W'(127)) ? 8'd127 : {1'b0, q1_q[6:0]};
    res_d.right_speed = neg0_q5 ? $signed(-cmd0) : $signed(cmd0);
    res_d.left_speed  = neg1_q5 ? $signed(-cmd1) : $signed(cmd1);
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign result_valid_o = vout_q;
  assign result_o       = res_q;

  // ----------------------------------------------------------- assertions
  `PWWS_ASSERT_DLY(a_fixed_latency, start && !busy, 6, result_valid_o, "result missing after transfer")
  `PWWS_ASSERT_IMP(a_no_spurious, result_valid_o, $past(start && !busy, 6), "result without transfer")
  `PWWS_ASSERT_IMP(a_cmd_range, result_valid_o, (result_o.left_speed != 8'sh80) && (result_o.right_speed != 8'sh80), "command out of range")
  `PWWS_ASSERT_IMP(a_mag_clamped, v4_q, (mag0_q <= {limit_q, 2'b00}) && (mag1_q <= {limit_q, 2'b00}), "speed above limit after clamp")

endmodule

>>> test/proximity_weighted_wheel_speed_test.sv
// ----------------------------------------------------------------------------
// proximity_weighted_wheel_speed_test
// Self-checking bench: sensor frames go in through start/busy and every
// result strobe is compared against an in-bench predictor of both wheel
// commands. Runs directed corner frames, register extremes and randomized
// register settings with random frames, with random idle cycles on the sender.
// ----------------------------------------------------------------------------
module proximity_weighted_wheel_speed_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_SENSORS  = pwws_pkg::NUM_SENSORS;
  localparam int PROX_W       = pwws_pkg::PROX_W;
  localparam int CMD_W        = pwws_pkg::CMD_W;
  localparam int CFG_IDX_W    = pwws_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W   = pwws_pkg::CFG_DATA_W;
  localparam int PIPE_DEPTH   = 6;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_LIMIT  = 200;
  localparam int RAND_PHASES  = 10;
  localparam int PHASE_FRAMES = 55;
  localparam int FRAME_W      = NUM_SENSORS * PROX_W;

  // indexes past the last register; writes there must be ignored
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_7 = 3'd7;

  localparam int WEIGHTS [2][NUM_SENSORS] = '{
    '{2, -2, -4, -12, 5, 2, 2, 2, 4},
    '{2, 2, 2, 5, -12, -4, -2, 2, 4}
  };

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  pwws_pkg::frame_t      frame_i;
  logic                  result_valid_o;
  pwws_pkg::result_t     result_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  // mirror of the register file
  longint cruise_cfg;
  longint dead_band_cfg;
  longint halve_cfg;
  longint limit_cfg;
  longint boost_band_cfg;
  longint scale_cfg;

  pwws_pkg::result_t wheel_cmd_q [$];
  int      mismatch_count  = 0;
  int      frames_sent     = 0;
  int      results_checked = 0;
  int      settings_count  = 0;
  int      cycle_count     = 0;
  bit      idle_on         = 1'b1;

  proximity_weighted_wheel_speed u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .frame_i        (frame_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint abs_l(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic signed [CMD_W-1:0] to_wheel_cmd(longint spd_q2);
    longint q;
    q = (abs_l(spd_q2) * scale_cfg) >>> 26;
    if (q > 127) q = 127;
    if (spd_q2 < 0) q = -q;
    return q[CMD_W-1:0];
  endfunction

  function automatic pwws_pkg::result_t predict_wheel_cmd(pwws_pkg::frame_t f);
    logic [FRAME_W-1:0] bits;
    longint pot [2];
    longint spd [2];
    longint lim;
    longint band;
    int     prox_val;
    pwws_pkg::result_t r;
    bits = f;
    for (int m = 0; m < 2; m++) begin
      pot[m] = 0;
      for (int s = 0; s < NUM_SENSORS; s++) begin
        prox_val = int'(bits[(NUM_SENSORS-1-s)*PROX_W +: PROX_W]);
        pot[m] += longint'(WEIGHTS[m][s]) * longint'(prox_val);
      end
      spd[m] = (3 * pot[m] + cruise_cfg) * 4;
    end
    if (abs_l(pot[0]) < dead_band_cfg && abs_l(pot[1]) < dead_band_cfg) begin
      spd[0] = cruise_cfg * 4;
      spd[1] = cruise_cfg * 4;
    end
    if (abs_l(pot[0]) > halve_cfg) begin
      spd[0] = spd[0] / 2;
    end else if (abs_l(pot[1]) > halve_cfg) begin
      spd[1] = spd[1] / 2;
    end
    band = boost_band_cfg * 4;
    if (spd[1] < band && spd[1] > -band && spd[0] < band && spd[0] > -band) begin
      spd[0] *= 20;
      spd[1] *= 20;
    end
    lim = limit_cfg * 4;
    for (int m = 0; m < 2; m++) begin
      if (spd[m] > lim) spd[m] = lim;
      else if (spd[m] < -lim) spd[m] = -lim;
    end
    // imbalance: s1 > 1.5*s0 or 1.5*s1 < s0, kept exact
    if (2 * spd[1] > 3 * spd[0] || 3 * spd[1] < 2 * spd[0]) begin
      spd[0] = spd[0] / 2;
      spd[1] = spd[1] / 2;
    end
    r.left_speed  = to_wheel_cmd(spd[1]);
    r.right_speed = to_wheel_cmd(spd[0]);
    return r;
  endfunction

  task automatic load_reset_values();
    cruise_cfg     = longint'(pwws_pkg::CRUISE_SPEED_RST);
    dead_band_cfg  = longint'(pwws_pkg::DEAD_BAND_RST);
    halve_cfg      = longint'(pwws_pkg::HALVE_THRESHOLD_RST);
    limit_cfg      = longint'(pwws_pkg::SPEED_LIMIT_RST);
    boost_band_cfg = longint'(pwws_pkg::NEAR_ZERO_BAND_RST);
    scale_cfg      = longint'(pwws_pkg::INVERSE_SCALE_RST);
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic queue_expected(input pwws_pkg::result_t r);
    wheel_cmd_q.insert(wheel_cmd_q.size(), r);
  endtask

  always @(posedge clk_i) begin
    pwws_pkg::result_t exp_cmd;
    if (rst_ni && result_valid_o) begin
      if (wheel_cmd_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: left %0d right %0d",
                                  result_o.left_speed, result_o.right_speed));
      end else begin
        exp_cmd = wheel_cmd_q.pop_front();
        results_checked++;
        if (result_o.left_speed !== exp_cmd.left_speed)
          report_mismatch($sformatf("left_speed got %0d want %0d",
                                    result_o.left_speed, exp_cmd.left_speed));
        if (result_o.right_speed !== exp_cmd.right_speed)
          report_mismatch($sformatf("right_speed got %0d want %0d",
                                    result_o.right_speed, exp_cmd.right_speed));
      end
    end
  end

  // ---------------------------------------------------------------- drivers

  task automatic send_frame(input pwws_pkg::frame_t f);
    if (idle_on && $urandom_range(99) < 16) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    start   <= 1'b1;
    frame_i <= f;
    do @(posedge clk_i); while (busy);
    queue_expected(predict_wheel_cmd(f));
    frames_sent++;
  endtask

  // stop sending and wait for every pending result, then let the pipe empty
  task automatic drain_results();
    int waited;
    waited = 0;
    start <= 1'b0;
    while (wheel_cmd_q.size() > 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (wheel_cmd_q.size() > 0) begin
      report_mismatch($sformatf("%0d results never arrived", wheel_cmd_q.size()));
      wheel_cmd_q.delete();
    end
    repeat (PIPE_DEPTH + 4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      pwws_pkg::REG_CRUISE_SPEED:    cruise_cfg     = longint'(data & 24'h00FFFF);
      pwws_pkg::REG_DEAD_BAND:       dead_band_cfg  = longint'(data & 24'h00FFFF);
      pwws_pkg::REG_HALVE_THRESHOLD: halve_cfg      = longint'(data & 24'h03FFFF);
      pwws_pkg::REG_SPEED_LIMIT:     limit_cfg      = longint'(data & 24'h00FFFF);
      pwws_pkg::REG_NEAR_ZERO_BAND:  boost_band_cfg = longint'(data & 24'h0003FF);
      pwws_pkg::REG_INVERSE_SCALE:   scale_cfg      = longint'(data & 24'hFFFFFF);
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------- stimulus

  function automatic pwws_pkg::frame_t uniform_frame(input int unsigned v);
    logic [FRAME_W-1:0] bits;
    for (int s = 0; s < NUM_SENSORS; s++)
      bits[(NUM_SENSORS-1-s)*PROX_W +: PROX_W] = v[PROX_W-1:0];
    return pwws_pkg::frame_t'(bits);
  endfunction

  // mix of full-range, small, near-uniform and mostly-small frames; the weight rows nearly
  // cancel on uniform frames, which reaches the deadband and boost paths
  function automatic pwws_pkg::frame_t random_frame();
    logic [FRAME_W-1:0] bits;
    int unsigned kind;
    int unsigned base;
    int unsigned v;
    kind = $urandom_range(3);
    base = $urandom_range(4095);
    for (int s = 0; s < NUM_SENSORS; s++) begin
      case (kind)
        0: v = $urandom_range(4095);
        1: v = $urandom_range(31);
        2: begin
          v = base + $urandom_range(16);
          if (v > 4095) v = 4095;
        end
        default: v = ($urandom_range(3) == 0) ? $urandom_range(4095) : $urandom_range(7);
      endcase
      bits[(NUM_SENSORS-1-s)*PROX_W +: PROX_W] = v[PROX_W-1:0];
    end
    return pwws_pkg::frame_t'(bits);
  endfunction

  // value for a register of the given width, junk above the width
  function automatic logic [CFG_DATA_W-1:0] random_reg_value(input int unsigned width,
                                                             input int unsigned typical);
    logic [CFG_DATA_W-1:0] mask;
    logic [CFG_DATA_W-1:0] v;
    mask = (CFG_DATA_W'(1) << width) - CFG_DATA_W'(1);
    case ($urandom_range(5))
      0: v = '0;
      1: v = mask;
      2, 3: v = CFG_DATA_W'($urandom_range(typical * 2));
      default: v = CFG_DATA_W'($urandom);
    endcase
    return (v & mask) | (CFG_DATA_W'($urandom) & ~mask);
  endfunction

  task automatic test_default_frames();
    logic [FRAME_W-1:0] bits;
    send_frame(uniform_frame(0));
    send_frame(uniform_frame(4095));
    for (int s = 0; s < NUM_SENSORS; s++) begin
      bits = '0;
      bits[(NUM_SENSORS-1-s)*PROX_W +: PROX_W] = '1;
      send_frame(pwws_pkg::frame_t'(bits));
    end
    drain_results();
    settings_count++;
  endtask

  task automatic test_register_extremes();
    // writes past the register file change nothing
    write_reg(REG_UNUSED_6, 24'hFFFFFF);
    write_reg(REG_UNUSED_7, 24'h000000);
    send_frame(uniform_frame(700));
    drain_results();

    // upper data bits set on the cruise, deadband, halve and boost-band registers
    write_reg(pwws_pkg::REG_CRUISE_SPEED,    24'hFFFFFF);
    write_reg(pwws_pkg::REG_DEAD_BAND,       24'hFF0000);
    write_reg(pwws_pkg::REG_HALVE_THRESHOLD, 24'hFFFFFF);
    write_reg(pwws_pkg::REG_NEAR_ZERO_BAND,  24'hFFFFFF);
    send_frame(uniform_frame(0));
    send_frame(uniform_frame(4095));
    drain_results();

    // zero limit forces both commands to zero
    write_reg(pwws_pkg::REG_SPEED_LIMIT, 24'h000000);
    send_frame(uniform_frame(4095));
    send_frame(random_frame());
    drain_results();

    // scale extremes
    write_reg(pwws_pkg::REG_SPEED_LIMIT,   24'h00FFFF);
    write_reg(pwws_pkg::REG_INVERSE_SCALE, 24'h000000);
    send_frame(uniform_frame(1234));
    send_frame(random_frame());
    drain_results();
    write_reg(pwws_pkg::REG_INVERSE_SCALE, 24'hFFFFFF);
    send_frame(uniform_frame(0));
    send_frame(uniform_frame(2048));
    drain_results();

    // small cruise, no deadband, wide boost band
    write_reg(pwws_pkg::REG_CRUISE_SPEED,    24'd10);
    write_reg(pwws_pkg::REG_DEAD_BAND,       24'd0);
    write_reg(pwws_pkg::REG_NEAR_ZERO_BAND,  24'd1023);
    send_frame(uniform_frame(3));
    send_frame(uniform_frame(0));
    drain_results();

    // zero cruise inside a maximal deadband
    write_reg(pwws_pkg::REG_CRUISE_SPEED, 24'd0);
    write_reg(pwws_pkg::REG_DEAD_BAND,    24'h00FFFF);
    send_frame(uniform_frame(4095));
    drain_results();
    settings_count += 7;
  endtask

  task automatic test_random_settings();
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph == 0) begin
        write_reg(pwws_pkg::REG_CRUISE_SPEED,
                  CFG_DATA_W'(pwws_pkg::CRUISE_SPEED_RST));
        write_reg(pwws_pkg::REG_DEAD_BAND,
                  CFG_DATA_W'(pwws_pkg::DEAD_BAND_RST));
        write_reg(pwws_pkg::REG_HALVE_THRESHOLD,
                  CFG_DATA_W'(pwws_pkg::HALVE_THRESHOLD_RST));
        write_reg(pwws_pkg::REG_SPEED_LIMIT,
                  CFG_DATA_W'(pwws_pkg::SPEED_LIMIT_RST));
        write_reg(pwws_pkg::REG_NEAR_ZERO_BAND,
                  CFG_DATA_W'(pwws_pkg::NEAR_ZERO_BAND_RST));
        write_reg(pwws_pkg::REG_INVERSE_SCALE,
                  CFG_DATA_W'(pwws_pkg::INVERSE_SCALE_RST));
      end else if (ph == 1) begin
        write_reg(pwws_pkg::REG_CRUISE_SPEED,    CFG_DATA_W'($urandom_range(150)));
        write_reg(pwws_pkg::REG_DEAD_BAND,       CFG_DATA_W'($urandom_range(3)));
        write_reg(pwws_pkg::REG_HALVE_THRESHOLD, CFG_DATA_W'($urandom_range(100, 2000)));
        write_reg(pwws_pkg::REG_SPEED_LIMIT,     CFG_DATA_W'($urandom_range(500, 65535)));
        write_reg(pwws_pkg::REG_NEAR_ZERO_BAND,  CFG_DATA_W'($urandom_range(200, 1023)));
        write_reg(pwws_pkg::REG_INVERSE_SCALE,
                  CFG_DATA_W'($urandom_range(100000, 16777215)));
      end else begin
        write_reg(pwws_pkg::REG_CRUISE_SPEED,    random_reg_value(16, 30000));
        write_reg(pwws_pkg::REG_DEAD_BAND,       random_reg_value(16, 1000));
        write_reg(pwws_pkg::REG_HALVE_THRESHOLD, random_reg_value(18, 2500));
        write_reg(pwws_pkg::REG_SPEED_LIMIT,     random_reg_value(16, 24000));
        write_reg(pwws_pkg::REG_NEAR_ZERO_BAND,  random_reg_value(10, 50));
        write_reg(pwws_pkg::REG_INVERSE_SCALE,   random_reg_value(24, 11639));
      end
      settings_count++;
      // one phase runs back-to-back with no idle cycles
      idle_on = (ph != 4);
      for (int n = 0; n < PHASE_FRAMES; n++) begin
        send_frame(random_frame());
        // hold off once mid-phase until everything in flight has come back
        if (ph == 5 && n == PHASE_FRAMES / 2)
          drain_results();
      end
      drain_results();
    end
    idle_on = 1'b1;
  endtask

  initial begin
    rst_ni      <= 1'b0;
    start       <= 1'b0;
    frame_i     <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= '0;
    cfg_data_i  <= '0;
    load_reset_values();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_frames();
    test_register_extremes();
    test_random_settings();
    drain_results();

    $display("Covered %0d frames under %0d register settings, %0d results compared",
             frames_sent, settings_count, results_checked);
    $display("Included zero limit, zero and full scale, ignored writes, %0d mismatches",
             mismatch_count);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/pwws_pkg.sv
rtl/proximity_weighted_wheel_speed.sv
test/proximity_weighted_wheel_speed_test.sv
